// ===== sv/ptd_pkg.sv =====
// Shared types and codes for the periodic task dispatcher.
`default_nettype none
package ptd_pkg;

   // Defaults for the top-level parameters
   localparam int          MAX_TASKS_DEF  = 16;
   localparam logic [31:0] WRAP_LIMIT_DEF = 32'd4294960000;

   // Request opcodes
   localparam logic [2:0] OP_TICK    = 3'd0;
   localparam logic [2:0] OP_CREATE  = 3'd1;
   localparam logic [2:0] OP_UPDATE  = 3'd2;
   localparam logic [2:0] OP_SUSPEND = 3'd3;
   localparam logic [2:0] OP_RESUME  = 3'd4;
   localparam logic [2:0] OP_SCAN    = 3'd5;

   // Response kinds
   localparam logic [1:0] KIND_ACK      = 2'd0;
   localparam logic [1:0] KIND_DISPATCH = 2'd1;
   localparam logic [1:0] KIND_FINISH   = 2'd2;

   // Register index (address bit 2 selects the word)
   localparam logic CSR_TASK_COUNT = 1'b0;

   // One response transaction
   typedef struct packed {
      logic        valid;
      logic [1:0]  kind;
      logic [3:0]  task_number;
      logic        first_time;
      logic [31:0] tick_value;
      logic        accepted;
      logic        last;
   } rsp_type;

endpackage
`default_nettype wire

// ===== sv/ptd_engine.sv =====
// Task table, tick counter and scan sequencer of the periodic task dispatcher.
`default_nettype none
module ptd_engine
   import ptd_pkg::*;
#(
   parameter int          MAX_TASKS  = MAX_TASKS_DEF,
   parameter logic [31:0] WRAP_LIMIT = WRAP_LIMIT_DEF,
   localparam int         IDX_W      = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1,
   localparam int         CNT_W      = $clog2(MAX_TASKS + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [2:0]       req_opcode,
   input  wire logic [3:0]       req_task_index,
   input  wire logic [31:0]      req_period,
   input  wire logic [CNT_W-1:0] live_count,
   output logic                  busy,
   output rsp_type               rsp
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [31:0]          tick_ff, tick_in;
   logic [MAX_TASKS-1:0] free_ff, free_in;
   logic [MAX_TASKS-1:0] ready_ff, ready_in;
   logic [MAX_TASKS-1:0] first_ff, first_in;
   logic [MAX_TASKS-1:0] susp_ff, susp_in;
   logic [IDX_W-1:0]     proc_ff, proc_in;
   rsp_type              rsp_ff, rsp_in;

   // Entry memory: {period, next_due}
   logic [63:0]          mem [MAX_TASKS];
   logic [63:0]          rd_data_ff;
   logic                 rd_en, wr_en;
   logic [IDX_W-1:0]     rd_addr, wr_addr;
   logic [63:0]          wr_data;

   logic                 accept;
   logic [31:0]          idx_ext, cnt_ext, proc_ext;
   logic                 idx_ok;
   logic [IDX_W-1:0]     idx_a;
   logic                 proc_last;
   logic [31:0]          rd_next, rd_period;
   logic                 p_free, wrap_hit, due, fire;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign idx_ext   = 32'(req_task_index);
   assign cnt_ext   = 32'(live_count);
   assign proc_ext  = 32'(proc_ff);
   assign idx_ok    = idx_ext < cnt_ext;
   assign idx_a     = idx_ext[IDX_W-1:0];
   assign proc_last = (proc_ext + 32'd1) == cnt_ext;
   assign rd_next   = rd_data_ff[31:0];
   assign rd_period = rd_data_ff[63:32];

   // Classify the entry whose memory word is on the read data
   assign p_free   = free_ff[proc_ff];
   assign wrap_hit = (state_ff == ST_SCAN) && !p_free && (tick_ff > WRAP_LIMIT);
   assign due      = (state_ff == ST_SCAN) && !p_free && !wrap_hit &&
                     ready_ff[proc_ff] && (rd_next <= tick_ff);
   assign fire     = ((state_ff == ST_SCAN) && p_free) || due;

   // Memory port control: program on create/update, reload next-due on scan
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_a;
      wr_data = {req_period, req_period};
      if (accept && (req_opcode == OP_CREATE || req_opcode == OP_UPDATE) && idx_ok) begin
         wr_en   = 1'b1;
         wr_data = {req_period,
                    (req_opcode == OP_CREATE) ? req_period : tick_ff + req_period};
      end else if (due) begin
         wr_en   = 1'b1;
         wr_addr = proc_ff;
         wr_data = {rd_period, tick_ff + rd_period};
      end
   end

   // Prefetch the next entry while the current one is processed
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      if (accept && req_opcode == OP_SCAN && cnt_ext != 32'd0) begin
         rd_en = 1'b1;
      end else if (state_ff == ST_SCAN && !proc_last) begin
         rd_en   = 1'b1;
         rd_addr = IDX_W'(proc_ext + 32'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Sequencer and flag updates
   always_comb begin
      state_in = state_ff;
      tick_in  = tick_ff;
      free_in  = free_ff;
      ready_in = ready_ff;
      first_in = first_ff;
      susp_in  = susp_ff;
      proc_in  = proc_ff;
      rsp_in   = '{valid: 1'b0, kind: KIND_ACK, task_number: 4'd0, first_time: 1'b0,
                   tick_value: tick_ff, accepted: 1'b1, last: 1'b1};
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_in.valid = 1'b1;
               case (req_opcode)
                  OP_TICK: begin
                     tick_in           = tick_ff + 32'd1;
                     rsp_in.tick_value = tick_ff + 32'd1;
                  end
                  OP_CREATE, OP_UPDATE: begin
                     if (idx_ok) begin
                        free_in[idx_a]  = (req_period == 32'd0);
                        ready_in[idx_a] = 1'b1;
                     end
                     rsp_in.task_number = req_task_index;
                     rsp_in.accepted    = idx_ok;
                  end
                  OP_SUSPEND, OP_RESUME: begin
                     if (idx_ok) begin
                        susp_in[idx_a] = (req_opcode == OP_SUSPEND);
                     end
                     rsp_in.task_number = req_task_index;
                     rsp_in.accepted    = idx_ok;
                  end
                  OP_SCAN: begin
                     if (cnt_ext == 32'd0) begin
                        rsp_in.kind = KIND_FINISH;
                     end else begin
                        rsp_in.valid = 1'b0;
                        state_in     = ST_SCAN;
                        proc_in      = '0;
                     end
                  end
                  default: begin
                     rsp_in.accepted = 1'b0;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // Drop all timing of live entries once the tick passes the wrap limit
            if (wrap_hit) begin
               for (int j = 0; j < MAX_TASKS; j++) begin
                  if (32'(j) < cnt_ext) begin
                     free_in[j]  = 1'b0;
                     ready_in[j] = 1'b0;
                  end
               end
               tick_in = 32'd0;
            end
            if (fire) begin
               first_in[proc_ff] = 1'b0;
               if (!susp_ff[proc_ff]) begin
                  rsp_in.valid       = 1'b1;
                  rsp_in.kind        = KIND_DISPATCH;
                  rsp_in.task_number = proc_ext[3:0];
                  rsp_in.first_time  = first_ff[proc_ff];
                  rsp_in.last        = 1'b0;
               end
            end
            if (proc_last) begin
               state_in = ST_FINISH;
            end else begin
               proc_in = IDX_W'(proc_ext + 32'd1);
            end
         end
         ST_FINISH: begin
            rsp_in.valid = 1'b1;
            rsp_in.kind  = KIND_FINISH;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= '0;
         free_ff      <= '0;
         ready_ff     <= '0;
         first_ff     <= '1;
         susp_ff      <= '0;
         rsp_ff.valid <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         free_ff      <= free_in;
         ready_ff     <= ready_in;
         first_ff     <= first_in;
         susp_ff      <= susp_in;
         rsp_ff.valid <= rsp_in.valid;
      end
      proc_ff            <= proc_in;
      rsp_ff.kind        <= rsp_in.kind;
      rsp_ff.task_number <= rsp_in.task_number;
      rsp_ff.first_time  <= rsp_in.first_time;
      rsp_ff.tick_value  <= rsp_in.tick_value;
      rsp_ff.accepted    <= rsp_in.accepted;
      rsp_ff.last        <= rsp_in.last;
   end

   assign rsp = rsp_ff;

   // The finish step always delivers the closing scan transaction
   a_finish_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH |=> rsp_ff.valid && rsp_ff.kind == KIND_FINISH && rsp_ff.last)
      else $error("scan finish transaction missing");

   // Every non-scan request answers in the next cycle with a closing transaction
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      accept && req_opcode != OP_SCAN |=> rsp_ff.valid && rsp_ff.last)
      else $error("single-step request not answered");

   // Writeback and prefetch never address the same entry
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rd_en && wr_en |-> rd_addr != wr_addr)
      else $error("memory read and write collide");

   // Dispatches never close a scan
   a_dispatch_open: assert property (@(posedge clock) disable iff (reset)
      rsp_ff.valid && rsp_ff.kind == KIND_DISPATCH |-> !rsp_ff.last && busy)
      else $error("dispatch marked last or outside scan");

endmodule
`default_nettype wire

// ===== sv/periodic_task_dispatcher.sv =====
// Top level of the periodic task dispatcher: register port and request/response ports.
//
// A request is taken when start is high and busy is low. Tick, create, update,
// suspend, resume and unknown opcodes answer with one transaction in the next
// cycle. A scan over N live entries keeps busy high while the entries are walked
// and then through a finish step: the entry memory's single read port streams one
// entry per cycle (prefetch of the next entry overlaps the next-due reload of the
// current one), then the finish step delivers the scan-finished transaction; a scan
// with no live entries answers in the next cycle. Each response is valid for exactly
// one cycle on rsp_valid and cannot be held off. No clearing pass follows reset.
`default_nettype none
module periodic_task_dispatcher
   import ptd_pkg::*;
#(
   parameter int          MAX_TASKS  = MAX_TASKS_DEF,
   parameter logic [31:0] WRAP_LIMIT = WRAP_LIMIT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_opcode,
   input  wire logic [3:0]  req_task_index,
   input  wire logic [31:0] req_period,
   // response channel
   output logic             rsp_valid,
   output logic [1:0]       rsp_kind,
   output logic [3:0]       rsp_task_number,
   output logic             rsp_first_time,
   output logic [31:0]      rsp_tick_value,
   output logic             rsp_accepted,
   output logic             rsp_last,
   // register port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int CNT_W = $clog2(MAX_TASKS + 1);

   logic [4:0]       task_count_ff, task_count_in;
   logic             csr_write;
   logic [31:0]      tc_ext;
   logic [31:0]      live_ext;
   logic [CNT_W-1:0] live_count;
   rsp_type          rsp;

   // Register write and readback
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign task_count_in = (csr_write && paddr[2] == CSR_TASK_COUNT) ? pwdata[4:0]
                                                                    : task_count_ff;
   assign prdata    = (paddr[2] == CSR_TASK_COUNT) ? {27'd0, task_count_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         task_count_ff <= '0;
      end else begin
         task_count_ff <= task_count_in;
      end
   end

   // Clamp the programmed count to the table depth
   assign tc_ext     = 32'(task_count_ff);
   assign live_ext   = (tc_ext > 32'(MAX_TASKS)) ? 32'(MAX_TASKS) : tc_ext;
   assign live_count = live_ext[CNT_W-1:0];

   ptd_engine #(
      .MAX_TASKS  (MAX_TASKS),
      .WRAP_LIMIT (WRAP_LIMIT)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_opcode     (req_opcode),
      .req_task_index (req_task_index),
      .req_period     (req_period),
      .live_count     (live_count),
      .busy           (busy),
      .rsp            (rsp)
   );

   assign rsp_valid       = rsp.valid;
   assign rsp_kind        = rsp.kind;
   assign rsp_task_number = rsp.task_number;
   assign rsp_first_time  = rsp.first_time;
   assign rsp_tick_value  = rsp.tick_value;
   assign rsp_accepted    = rsp.accepted;
   assign rsp_last        = rsp.last;

endmodule
`default_nettype wire

// ===== test/periodic_task_dispatcher_test.sv =====
// Self-checking testbench for the periodic task dispatcher top level.
`timescale 1ns / 100ps

module periodic_task_dispatcher_test;
   import ptd_pkg::*;

   // Cycles without any accepted transaction before the run is abandoned
   localparam int STALL_LIMIT = 1000;
   localparam logic [2:0] TASK_COUNT_ADDR = {CSR_TASK_COUNT, 2'b00};
   // Opcodes left undefined by the block
   localparam logic [2:0] OP_SPARE_LOW  = 3'd6;
   localparam logic [2:0] OP_SPARE_HIGH = 3'd7;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_opcode;
   logic [3:0]  req_task_index;
   logic [31:0] req_period;
   logic        rsp_valid;
   logic [1:0]  rsp_kind;
   logic [3:0]  rsp_task_number;
   logic        rsp_first_time;
   logic [31:0] rsp_tick_value;
   logic        rsp_accepted;
   logic        rsp_last;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   periodic_task_dispatcher dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_task_index  (req_task_index),
      .req_period      (req_period),
      .rsp_valid       (rsp_valid),
      .rsp_kind        (rsp_kind),
      .rsp_task_number (rsp_task_number),
      .rsp_first_time  (rsp_first_time),
      .rsp_tick_value  (rsp_tick_value),
      .rsp_accepted    (rsp_accepted),
      .rsp_last        (rsp_last),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   // Shadow copy of the task table
   logic [31:0] tick_now;
   logic [31:0] due_tick     [MAX_TASKS_DEF];
   logic [31:0] period_ticks [MAX_TASKS_DEF];
   logic        runs_free    [MAX_TASKS_DEF];
   logic        armed        [MAX_TASKS_DEF];
   logic        never_run    [MAX_TASKS_DEF];
   logic        on_hold      [MAX_TASKS_DEF];
   logic [4:0]  task_limit;

   rsp_type expected_results[$];
   int      failures;
   int      idle_pct;
   int      stall_cycles;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic rsp_type result_of(input logic [1:0] kind, input logic [3:0] num,
                                         input logic first, input logic [31:0] tick,
                                         input logic acc, input logic fin);
      rsp_type r;
      r.valid       = 1'b1;
      r.kind        = kind;
      r.task_number = num;
      r.first_time  = first;
      r.tick_value  = tick;
      r.accepted    = acc;
      r.last        = fin;
      return r;
   endfunction

   task automatic clear_table();
      tick_now   = '0;
      task_limit = '0;
      for (int i = 0; i < MAX_TASKS_DEF; i++) begin
         due_tick[i]     = '0;
         period_ticks[i] = '0;
         runs_free[i]    = 1'b0;
         armed[i]        = 1'b0;
         never_run[i]    = 1'b1;
         on_hold[i]      = 1'b0;
      end
   endtask

   function automatic int live_entries();
      return (task_limit > MAX_TASKS_DEF) ? MAX_TASKS_DEF : int'(task_limit);
   endfunction

   // Advance the shadow table by one transaction and queue what it should emit
   task automatic predict_dispatches(input logic [2:0] op, input logic [3:0] idx,
                                     input logic [31:0] per);
      int live;
      bit in_range;
      live     = live_entries();
      in_range = int'(idx) < live;
      case (op)
         OP_TICK: begin
            tick_now = tick_now + 32'd1;
            expected_results.push_back(result_of(KIND_ACK, 4'd0, 1'b0, tick_now, 1'b1, 1'b1));
         end
         OP_CREATE, OP_UPDATE: begin
            if (in_range) begin
               runs_free[idx]    = (per == 32'd0);
               period_ticks[idx] = per;
               due_tick[idx]     = (op == OP_CREATE) ? per : tick_now + per;
               armed[idx]        = 1'b1;
            end
            expected_results.push_back(result_of(KIND_ACK, idx, 1'b0, tick_now, in_range, 1'b1));
         end
         OP_SUSPEND, OP_RESUME: begin
            if (in_range) on_hold[idx] = (op == OP_SUSPEND);
            expected_results.push_back(result_of(KIND_ACK, idx, 1'b0, tick_now, in_range, 1'b1));
         end
         OP_SCAN: begin
            for (int i = 0; i < live; i++) begin
               if (runs_free[i]) begin
                  if (!on_hold[i])
                     expected_results.push_back(result_of(KIND_DISPATCH, 4'(i), never_run[i],
                                                          tick_now, 1'b1, 1'b0));
                  never_run[i] = 1'b0;
               end else begin
                  // Clear all timing once the tick passes the wrap threshold
                  if (tick_now > WRAP_LIMIT_DEF) begin
                     for (int j = 0; j < live; j++) begin
                        due_tick[j]     = '0;
                        period_ticks[j] = '0;
                        runs_free[j]    = 1'b0;
                        armed[j]        = 1'b0;
                     end
                     tick_now = '0;
                  end
                  if (armed[i] && due_tick[i] <= tick_now) begin
                     due_tick[i] = tick_now + period_ticks[i];
                     if (!on_hold[i])
                        expected_results.push_back(result_of(KIND_DISPATCH, 4'(i), never_run[i],
                                                             tick_now, 1'b1, 1'b0));
                     never_run[i] = 1'b0;
                  end
               end
            end
            expected_results.push_back(result_of(KIND_FINISH, 4'd0, 1'b0, tick_now, 1'b1, 1'b1));
         end
         default: begin
            expected_results.push_back(result_of(KIND_ACK, 4'd0, 1'b0, tick_now, 1'b0, 1'b1));
         end
      endcase
   endtask

   function automatic bit take_break();
      return $urandom_range(99) < idle_pct;
   endfunction

   // Present one request, with random idle cycles ahead of it, and hold until accepted
   task automatic send_item(input logic [2:0] op, input logic [3:0] idx, input logic [31:0] per);
      while (take_break()) begin
         start          <= 1'b0;
         req_opcode     <= 3'($urandom());
         req_task_index <= 4'($urandom());
         req_period     <= $urandom();
         @(posedge clock);
      end
      start          <= 1'b1;
      req_opcode     <= op;
      req_task_index <= idx;
      req_period     <= per;
      do @(posedge clock); while (busy);
      predict_dispatches(op, idx, per);
   endtask

   // Drop start and wait until every queued result has come out
   task automatic drain();
      start <= 1'b0;
      while (expected_results.size() != 0 || busy) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Write task_count over the register port, then read it back
   task automatic set_task_count(input logic [4:0] n);
      logic [31:0] word;
      drain();
      word    = {27'($urandom_range(32'h07FF_FFFF)), n};
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= TASK_COUNT_ADDR;
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      task_limit = word[4:0];
      penable <= 1'b0;
      pwrite  <= 1'b0;
      pwdata  <= $urandom();
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {27'd0, task_limit}) begin
         $display("%0t: task_count readback mismatch, expected %0h, actual %0h",
                  $time, {27'd0, task_limit}, prdata);
         failures++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic logic [31:0] pick_period();
      int r;
      r = $urandom_range(99);
      if (r < 25) return 32'd0;
      if (r < 80) return $urandom_range(6, 1);
      if (r < 90) return $urandom();
      return 32'hFFFF_FFFF - $urandom_range(3);
   endfunction

   function automatic logic [3:0] pick_index();
      int live;
      live = live_entries();
      if (live > 0 && $urandom_range(99) < 85) return 4'($urandom_range(live - 1));
      return 4'($urandom());
   endfunction

   // One random request, weighted toward ticks and scans
   task automatic send_random_item();
      int r;
      r = $urandom_range(99);
      if (r < 30)      send_item(OP_TICK, 4'($urandom()), $urandom());
      else if (r < 45) send_item(OP_CREATE, pick_index(), pick_period());
      else if (r < 55) send_item(OP_UPDATE, pick_index(), pick_period());
      else if (r < 62) send_item(OP_SUSPEND, pick_index(), $urandom());
      else if (r < 69) send_item(OP_RESUME, pick_index(), $urandom());
      else if (r < 90) send_item(OP_SCAN, 4'($urandom()), $urandom());
      else if (r < 95) send_item($urandom_range(1) ? OP_SPARE_HIGH : OP_SPARE_LOW,
                                 4'($urandom()), $urandom());
      else             send_item(3'($urandom_range(4, 1)), 4'($urandom()), pick_period());
   endtask

   // Empty table: everything but tick is rejected or finishes at once
   task automatic test_empty_table();
      set_task_count(5'd0);
      send_item(OP_SCAN, 4'd0, 32'd0);
      send_item(OP_CREATE, 4'd0, 32'd5);
      send_item(OP_SPARE_LOW, 4'd15, 32'hFFFF_FFFF);
      send_item(OP_SPARE_HIGH, 4'd0, 32'd0);
      send_item(OP_TICK, 4'd0, 32'd0);
   endtask

   // Free-running, wrapped next-due, suspended and first-run entries
   task automatic test_entry_programming();
      set_task_count(5'd16);
      send_item(OP_CREATE, 4'd15, 32'd0);
      send_item(OP_CREATE, 4'd0, 32'hFFFF_FFFF);
      send_item(OP_CREATE, 4'd1, 32'd1);
      send_item(OP_UPDATE, 4'd2, 32'hFFFF_FFFF);
      send_item(OP_SUSPEND, 4'd1, 32'd0);
      send_item(OP_SCAN, 4'd0, 32'd0);
      send_item(OP_RESUME, 4'd1, 32'd0);
      send_item(OP_TICK, 4'd0, 32'd0);
      send_item(OP_TICK, 4'd0, 32'd0);
      send_item(OP_SCAN, 4'd0, 32'd0);
      send_item(OP_SUSPEND, 4'd15, 32'd0);
      send_item(OP_SCAN, 4'd0, 32'd0);
      send_item(OP_RESUME, 4'd15, 32'd0);
   endtask

   // Count above the table size, and indexes at and past a small count
   task automatic test_index_limits();
      set_task_count(5'd31);
      send_item(OP_CREATE, 4'd15, 32'd3);
      send_item(OP_SCAN, 4'd0, 32'd0);
      set_task_count(5'd3);
      send_item(OP_SUSPEND, 4'd3, 32'd0);
      send_item(OP_UPDATE, 4'd15, 32'd2);
      send_item(OP_RESUME, 4'd2, 32'd0);
      send_item(OP_SCAN, 4'd0, 32'd0);
   endtask

   // Random traffic over several table sizes, each phase first creating a random subset of its entries
   task automatic test_random_traffic();
      logic [4:0] counts [10];
      int         items;
      counts = '{5'd16, 5'd1, 5'd31, 5'd5, 5'd16, 5'd0, 5'd12, 5'd16, 5'd0, 5'd0};
      counts[8] = 5'($urandom_range(31));
      counts[9] = 5'($urandom_range(31));
      for (int p = 0; p < 10; p++) begin
         set_task_count(counts[p]);
         items = (counts[p] == 5'd0) ? 12 : 36;
         for (int i = 0; i < live_entries(); i++)
            if ($urandom_range(99) < 70) send_item(OP_CREATE, 4'(i), pick_period());
         for (int n = 0; n < items; n++) send_random_item();
      end
   endtask

   // Requests back to back with no idle cycles at all
   task automatic test_back_to_back();
      idle_pct = 0;
      set_task_count(5'd16);
      for (int n = 0; n < 80; n++) send_random_item();
      idle_pct = 34;
   endtask

   // Compare each result with the oldest expectation
   task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual kind %0h task %0h",
                     $time, rsp_kind, rsp_task_number);
            failures++;
         end else begin
            want = expected_results.pop_front();
            check_field("kind", 32'(want.kind), 32'(rsp_kind));
            check_field("task_number", 32'(want.task_number), 32'(rsp_task_number));
            check_field("first_time", 32'(want.first_time), 32'(rsp_first_time));
            check_field("tick_value", want.tick_value, rsp_tick_value);
            check_field("accepted", 32'(want.accepted), 32'(rsp_accepted));
            check_field("last", 32'(want.last), 32'(rsp_last));
         end
      end
   end

   // Abandon the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      failures       = 0;
      idle_pct       = 34;
      stall_cycles   = 0;
      reset          <= 1'b1;
      start          <= 1'b0;
      req_opcode     <= '0;
      req_task_index <= '0;
      req_period     <= '0;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;
      clear_table();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_table();
      test_entry_programming();
      test_index_limits();
      test_random_traffic();
      test_back_to_back();

      drain();
      repeat (20) @(posedge clock);
      if (failures == 0 && expected_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
